>>> sv/pccc_pkg.sv
// ============================================================================
// pccc_pkg
// Shared types and constants for the chipset configuration and control ports.
// ============================================================================
`default_nettype none

package pccc_pkg;

  localparam int unsigned CFG_ADDR_W   = 8;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned CFG_DEPTH    = 256;
  localparam int unsigned REGION_MAX   = 8;
  localparam int unsigned REGION_COUNT = 8;

  // Configuration entries that drive the shadow RAM masks
  localparam logic [CFG_ADDR_W-1:0] SHADOW_EN_IDX   = 8'h13;
  localparam logic [CFG_ADDR_W-1:0] SHADOW_TYPE_IDX = 8'h14;

  // System control port A bit positions
  localparam int unsigned CTLA_RESET_BIT = 0;
  localparam int unsigned CTLA_A20_BIT   = 1;
  localparam int unsigned CTLA_LOCK_BIT  = 3;

  // System control port B bit positions
  localparam int unsigned CTLB_GATE_BIT    = 0;
  localparam int unsigned CTLB_SPEAKER_BIT = 1;
  localparam int unsigned CTLB_REFRESH_BIT = 4;
  localparam int unsigned CTLB_TIMER_BIT   = 5;

  typedef enum logic {
    CMD_READ,
    CMD_WRITE
  } cmd_e;

  typedef enum logic [1:0] {
    PORT_INDEX,
    PORT_DATA,
    PORT_CTRL_A,
    PORT_CTRL_B
  } port_e;

  typedef struct packed {
    cmd_e                  cmd;
    port_e                 port_sel;
    logic [CFG_DATA_W-1:0] write_data;
    logic                  timer_two_output;
  } item_t;

  // Declared most significant first so that the packed form matches tdata
  typedef struct packed {
    logic                  cmos_lock;
    logic                  speaker_on;
    logic                  timer_two_gate;
    logic [REGION_MAX-1:0] shadow_write_mask;
    logic [REGION_MAX-1:0] shadow_read_mask;
    logic                  cpu_reset_pulse;
    logic                  a20_enable;
    logic [CFG_DATA_W-1:0] read_data;
  } res_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_ADDR_W-1:0] waddr;
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_ADDR_W-1:0] raddr;
  } cfg_req_t;

endpackage

`default_nettype wire

>>> sv/pccc_ram.sv
// ============================================================================
// pccc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
`default_nettype none

module pccc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/pccc_cfg_file.sv
// ============================================================================
// pccc_cfg_file
// 256-byte configuration file: RAM, per-entry valid bits for the zero reset
// value, and a bypass for a read that meets a write to the same entry.
// ============================================================================
`default_nettype none

module pccc_cfg_file
  import pccc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_req_t              req_i,
  output logic      [CFG_DATA_W-1:0] rdata_o
);

  logic [CFG_DEPTH-1:0]  valid_q;
  logic                  rd_valid_q;
  logic                  byp_hit_q;
  logic [CFG_DATA_W-1:0] byp_data_q;
  logic [CFG_DATA_W-1:0] ram_rdata;
  logic                  byp_hit_d;

  pccc_ram #(
    .WIDTH (CFG_DATA_W),
    .DEPTH (CFG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  assign byp_hit_d = req_i.we && (req_i.waddr == req_i.raddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      rd_valid_q <= valid_q[req_i.raddr];
      byp_hit_q  <= byp_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= req_i.wdata;
  end

  // Entries never written read as zero
  assign rdata_o = byp_hit_q  ? byp_data_q :
                   rd_valid_q ? ram_rdata  : '0;

endmodule

`default_nettype wire

>>> sv/pccc_regs.sv
// ============================================================================
// pccc_regs
// Port decode, control state and result formation for one access.
// ============================================================================
`default_nettype none

module pccc_regs
  import pccc_pkg::*;
#(
  parameter int unsigned REGION_COUNT = pccc_pkg::REGION_COUNT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire item_t                 item_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_rdata_i,
  output cfg_req_t                   cfg_req_o,
  output res_t                       res_o
);

  logic [CFG_ADDR_W-1:0] index_q, index_d;
  logic                  lock_q, lock_d;
  logic                  refresh_q, refresh_d;
  logic                  a20_q, a20_d;
  logic                  gate_q, gate_d;
  logic                  speaker_q, speaker_d;
  logic [REGION_MAX-1:0] shen_q, shen_d;
  logic [1:0]            kind_q, kind_d;
  logic [CFG_DATA_W-1:0] rdata;
  logic                  pulse;
  logic                  data_wr;
  logic [REGION_MAX-1:0] rmask;
  logic [REGION_MAX-1:0] wmask;

  always_comb begin
    index_d   = index_q;
    lock_d    = lock_q;
    refresh_d = refresh_q;
    a20_d     = a20_q;
    gate_d    = gate_q;
    speaker_d = speaker_q;
    rdata     = '0;
    pulse     = 1'b0;
    data_wr   = 1'b0;
    case (item_i.port_sel)
      PORT_INDEX: begin
        if (item_i.cmd == CMD_WRITE) begin
          index_d = item_i.write_data;
        end else begin
          rdata = index_q;
        end
      end
      PORT_DATA: begin
        if (item_i.cmd == CMD_WRITE) begin
          data_wr = 1'b1;
        end else begin
          rdata = cfg_rdata_i;
        end
      end
      PORT_CTRL_A: begin
        if (item_i.cmd == CMD_WRITE) begin
          lock_d = item_i.write_data[CTLA_LOCK_BIT];
          a20_d  = item_i.write_data[CTLA_A20_BIT];
          pulse  = item_i.write_data[CTLA_RESET_BIT];
        end else begin
          rdata[CTLA_LOCK_BIT] = lock_q;
          rdata[CTLA_A20_BIT]  = a20_q;
        end
      end
      PORT_CTRL_B: begin
        if (item_i.cmd == CMD_WRITE) begin
          gate_d    = item_i.write_data[CTLB_GATE_BIT];
          speaker_d = item_i.write_data[CTLB_SPEAKER_BIT];
        end else begin
          rdata[CTLB_GATE_BIT]    = gate_q;
          rdata[CTLB_SPEAKER_BIT] = speaker_q;
          rdata[CTLB_REFRESH_BIT] = refresh_q;
          rdata[CTLB_TIMER_BIT]   = item_i.timer_two_output;
          refresh_d               = ~refresh_q;
        end
      end
      default: begin
        rdata = '0;
      end
    endcase
  end

  // Mirror the two shadow entries so the masks need no extra RAM port
  always_comb begin
    shen_d = shen_q;
    kind_d = kind_q;
    if (data_wr && (index_q == SHADOW_EN_IDX)) begin
      shen_d = item_i.write_data[REGION_MAX-1:0];
    end
    if (data_wr && (index_q == SHADOW_TYPE_IDX)) begin
      kind_d = item_i.write_data[1:0];
    end
  end

  always_comb begin
    rmask = '0;
    wmask = '0;
    for (int unsigned i = 0; i < REGION_MAX && i < REGION_COUNT; i++) begin
      rmask[i] = shen_d[i] & kind_d[0];
      wmask[i] = shen_d[i] & kind_d[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q   <= '0;
      lock_q    <= 1'b0;
      refresh_q <= 1'b0;
      a20_q     <= 1'b1;
      gate_q    <= 1'b0;
      speaker_q <= 1'b0;
      shen_q    <= '0;
      kind_q    <= '0;
    end else if (adv_i) begin
      index_q   <= index_d;
      lock_q    <= lock_d;
      refresh_q <= refresh_d;
      a20_q     <= a20_d;
      gate_q    <= gate_d;
      speaker_q <= speaker_d;
      shen_q    <= shen_d;
      kind_q    <= kind_d;
    end
  end

  // Read ahead at the index the next access will see
  assign cfg_req_o.we    = adv_i && data_wr;
  assign cfg_req_o.waddr = index_q;
  assign cfg_req_o.wdata = item_i.write_data;
  assign cfg_req_o.raddr = adv_i ? index_d : index_q;

  assign res_o.read_data         = rdata;
  assign res_o.a20_enable        = a20_d;
  assign res_o.cpu_reset_pulse   = pulse;
  assign res_o.shadow_read_mask  = rmask;
  assign res_o.shadow_write_mask = wmask;
  assign res_o.timer_two_gate    = gate_d;
  assign res_o.speaker_on        = speaker_d;
  assign res_o.cmos_lock         = lock_d;

endmodule

`default_nettype wire

>>> sv/pc_chipset_config_and_control_ports.sv
// ============================================================================
// pc_chipset_config_and_control_ports
// Index/data configuration ports with system control ports A and B.
// ============================================================================
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   16b: write_data, timer_two_output       3b: cmd, port_sel
//   m_axis    out  32b: read_data, a20, reset pulse,       -
//                       shadow read/write masks, gate,
//                       speaker, cmos lock
//
// One transaction per cycle sustained while m_axis is ready; each access is
// decoded in the input register against the control state and the
// registered configuration file read, and then sits in the result register.
// Reset restores A20 on, all other state and the whole configuration file to
// zero, with no clearing pass. A stalled result holds the input register,
// which holds s_axis.
// ============================================================================
`default_nettype none

module pc_chipset_config_and_control_ports
  import pccc_pkg::*;
#(
  parameter int unsigned REGION_COUNT = pccc_pkg::REGION_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] write_data, [8] timer_two_output
  input  wire logic [2:0]  s_axis_tuser,  // [0] cmd, [2:1] port_sel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // [7:0] read_data, [8] a20_enable,
                                          // [9] cpu_reset_pulse,
                                          // [17:10] shadow_read_mask,
                                          // [25:18] shadow_write_mask,
                                          // [26] timer_two_gate,
                                          // [27] speaker_on, [28] cmos_lock
);

  item_t                 item_q;
  logic                  item_valid_q;
  res_t                  out_q;
  logic                  out_valid_q;
  logic                  adv;
  logic                  accept;
  res_t                  res;
  cfg_req_t              cfg_req;
  logic [CFG_DATA_W-1:0] cfg_rdata;

  assign adv           = item_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !item_valid_q || adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        item_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd              <= cmd_e'(s_axis_tuser[0]);
      item_q.port_sel         <= port_e'(s_axis_tuser[2:1]);
      item_q.write_data       <= s_axis_tdata[7:0];
      item_q.timer_two_output <= s_axis_tdata[8];
    end
    if (adv) begin
      out_q <= res;
    end
  end

  pccc_regs #(
    .REGION_COUNT (REGION_COUNT)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (item_q),
    .cfg_rdata_i (cfg_rdata),
    .cfg_req_o   (cfg_req),
    .res_o       (res)
  );

  pccc_cfg_file u_cfg_file (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cfg_req),
    .rdata_o (cfg_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

endmodule

`default_nettype wire

>>> sim/tb_pc_chipset_config_and_control_ports.sv
// ============================================================================
// tb_pc_chipset_config_and_control_ports
// Self-checking bench for the index/data configuration and control ports.
// Accesses go in over s_axis and a scoreboard predicts each result word from
// its own copy of the index, configuration file and control bits. Results
// from m_axis are compared field by field. Both sides idle at random, and
// the result side holds off once for a long stretch to back the block up.
// ============================================================================

module tb_pc_chipset_config_and_control_ports
  import pccc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  class ports_scoreboard;
    logic [7:0] index_q;
    logic [7:0] cfg_mem [0:255];
    logic       lock;
    logic       refresh;
    logic       a20;
    logic       gate;
    logic       speaker;
    res_t       expected_q [$];
    int         errors;

    function new();
      index_q = '0;
      foreach (cfg_mem[i]) cfg_mem[i] = '0;
      lock    = 1'b0;
      refresh = 1'b0;
      a20     = 1'b1;
      gate    = 1'b0;
      speaker = 1'b0;
      errors  = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Apply one accepted access to the shadow state and queue its result
    function void note_access(item_t it);
      res_t       r;
      logic [7:0] en;
      logic [7:0] kind;
      r = '0;
      if (it.cmd == CMD_WRITE) begin
        case (it.port_sel)
          PORT_INDEX: index_q = it.write_data;
          PORT_DATA:  cfg_mem[index_q] = it.write_data;
          PORT_CTRL_A: begin
            lock              = it.write_data[CTLA_LOCK_BIT];
            a20               = it.write_data[CTLA_A20_BIT];
            r.cpu_reset_pulse = it.write_data[CTLA_RESET_BIT];
          end
          default: begin
            gate    = it.write_data[CTLB_GATE_BIT];
            speaker = it.write_data[CTLB_SPEAKER_BIT];
          end
        endcase
      end else begin
        case (it.port_sel)
          PORT_INDEX: r.read_data = index_q;
          PORT_DATA:  r.read_data = cfg_mem[index_q];
          PORT_CTRL_A: begin
            r.read_data[CTLA_LOCK_BIT] = lock;
            r.read_data[CTLA_A20_BIT]  = a20;
          end
          default: begin
            r.read_data[CTLB_GATE_BIT]    = gate;
            r.read_data[CTLB_SPEAKER_BIT] = speaker;
            r.read_data[CTLB_REFRESH_BIT] = refresh;
            r.read_data[CTLB_TIMER_BIT]   = it.timer_two_output;
            refresh = ~refresh;
          end
        endcase
      end
      // Shadow masks follow the enable and type entries after this access
      en   = cfg_mem[SHADOW_EN_IDX];
      kind = cfg_mem[SHADOW_TYPE_IDX];
      for (int i = 0; i < REGION_MAX && i < REGION_COUNT; i++) begin
        if (en[i]) begin
          r.shadow_read_mask[i]  = kind[0];
          r.shadow_write_mask[i] = kind[1];
        end
      end
      r.a20_enable     = a20;
      r.timer_two_gate = gate;
      r.speaker_on     = speaker;
      r.cmos_lock      = lock;
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %02h actual %02h", $time, field, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no access pending, expected none actual %08h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare("read_data",         want.read_data,         got.read_data);
      compare("a20_enable",        8'(want.a20_enable),    8'(got.a20_enable));
      compare("cpu_reset_pulse",   8'(want.cpu_reset_pulse),
              8'(got.cpu_reset_pulse));
      compare("shadow_read_mask",  want.shadow_read_mask,  got.shadow_read_mask);
      compare("shadow_write_mask", want.shadow_write_mask, got.shadow_write_mask);
      compare("timer_two_gate",    8'(want.timer_two_gate), 8'(got.timer_two_gate));
      compare("speaker_on",        8'(want.speaker_on),    8'(got.speaker_on));
      compare("cmos_lock",         8'(want.cmos_lock),     8'(got.cmos_lock));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] write_data, [8] timer_two_output
  logic [2:0]  s_axis_tuser;   // [0] cmd, [2:1] port_sel
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] read_data, [8] a20, [9] reset pulse,
                               // [17:10] read mask, [25:18] write mask,
                               // [26] gate, [27] speaker, [28] cmos lock

  ports_scoreboard sb;
  int              n_sent;

  pc_chipset_config_and_control_ports dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Idle cycles before a transaction; every fourth stretch of 40 runs flat out
  function automatic int idle_cycles(int n);
    if ((n / 40) % 4 == 3) return 0;
    return $urandom_range(0, 6);
  endfunction

  task automatic send_access(cmd_e c, port_e p, logic [7:0] d, logic t);
    int    gap;
    item_t it;
    it.cmd              = c;
    it.port_sel         = p;
    it.write_data       = d;
    it.timer_two_output = t;
    gap = idle_cycles(n_sent);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, t, d};
    s_axis_tuser  <= {p, c};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_access(it);
    n_sent++;
  endtask

  // Result side: random stalls, and one long hold-off to fill the pipeline
  initial begin : result_sink
    int n_res;
    int hold;
    n_res = 0;
    @(posedge rst_ni);
    forever begin
      hold = (n_res == 150) ? 80 : idle_cycles(n_res);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(res_t'(m_axis_tdata[28:0]));
      n_res++;
    end
  end

  initial begin : stimulus
    int         kind;
    int         n_data;
    int         target;
    logic [7:0] idx;
    sb            = new();
    n_sent        = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of every port, refresh toggling across two reads
    send_access(CMD_READ,  PORT_INDEX,  8'h00, 1'b0);
    send_access(CMD_READ,  PORT_DATA,   8'hFF, 1'b1);
    send_access(CMD_READ,  PORT_CTRL_A, 8'h00, 1'b0);
    send_access(CMD_READ,  PORT_CTRL_B, 8'h00, 1'b0);
    send_access(CMD_READ,  PORT_CTRL_B, 8'hFF, 1'b1);
    // Shadow masks: enables set, each access type, then enables cleared
    send_access(CMD_WRITE, PORT_INDEX,  SHADOW_EN_IDX, 1'b0);
    send_access(CMD_WRITE, PORT_DATA,   8'hFF, 1'b1);
    send_access(CMD_READ,  PORT_DATA,   8'h00, 1'b0);
    send_access(CMD_WRITE, PORT_INDEX,  SHADOW_TYPE_IDX, 1'b0);
    send_access(CMD_WRITE, PORT_DATA,   8'h03, 1'b0);
    send_access(CMD_WRITE, PORT_DATA,   8'hFD, 1'b0);
    send_access(CMD_WRITE, PORT_DATA,   8'h02, 1'b0);
    send_access(CMD_WRITE, PORT_INDEX,  SHADOW_EN_IDX, 1'b0);
    send_access(CMD_WRITE, PORT_DATA,   8'h00, 1'b0);
    send_access(CMD_WRITE, PORT_DATA,   8'hA5, 1'b0);
    // Top of the index range: write, read back, then read the index
    send_access(CMD_WRITE, PORT_INDEX,  8'hFF, 1'b0);
    send_access(CMD_WRITE, PORT_DATA,   8'hFF, 1'b0);
    send_access(CMD_READ,  PORT_DATA,   8'h00, 1'b0);
    send_access(CMD_READ,  PORT_INDEX,  8'h00, 1'b0);
    // Control A: lock, A20 and reset pulse set, then all cleared
    send_access(CMD_WRITE, PORT_CTRL_A, 8'hFF, 1'b0);
    send_access(CMD_READ,  PORT_CTRL_A, 8'h00, 1'b0);
    send_access(CMD_WRITE, PORT_CTRL_A, 8'h00, 1'b0);
    send_access(CMD_READ,  PORT_CTRL_A, 8'h00, 1'b0);
    // Control B: gate and speaker set, then cleared
    send_access(CMD_WRITE, PORT_CTRL_B, 8'hFF, 1'b0);
    send_access(CMD_READ,  PORT_CTRL_B, 8'h00, 1'b1);
    send_access(CMD_WRITE, PORT_CTRL_B, 8'h00, 1'b0);
    send_access(CMD_WRITE, PORT_CTRL_A, 8'h0A, 1'b0);

    // Index-then-data sequences weighted towards the shadow entries, plus control and random accesses
    target = n_sent + 400;
    while (n_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        case ($urandom_range(0, 2))
          0:       idx = SHADOW_EN_IDX + 8'($urandom_range(0, 1));
          1:       idx = 8'($urandom_range(0, 7));
          default: idx = 8'($urandom_range(0, 255));
        endcase
        send_access(CMD_WRITE, PORT_INDEX, idx, 1'($urandom_range(0, 1)));
        n_data = $urandom_range(1, 3);
        repeat (n_data)
          send_access(cmd_e'($urandom_range(0, 1)), PORT_DATA,
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind < 6) begin
        send_access(cmd_e'($urandom_range(0, 1)), PORT_CTRL_A,
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind < 8) begin
        send_access(cmd_e'($urandom_range(0, 1)), PORT_CTRL_B,
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_access(cmd_e'($urandom_range(0, 1)), port_e'($urandom_range(0, 3)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then idle to catch any stray result
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("pc_chipset_config_and_control_ports verification clean");
    end else begin
      $display("pc_chipset_config_and_control_ports verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000;
    $display("pc_chipset_config_and_control_ports verification failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/pccc_pkg.sv
sv/pccc_ram.sv
sv/pccc_cfg_file.sv
sv/pccc_regs.sv
sv/pc_chipset_config_and_control_ports.sv
sim/tb_pc_chipset_config_and_control_ports.sv
